// File: hdl/boolean_expression_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boolean expression evaluator
// Clocked immediate-consequence and next-cycle forms, reset disabled.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_EXPRESSION_EVALUATOR_MACROS_SVH
`define BOOLEAN_EXPRESSION_EVALUATOR_MACROS_SVH

// consequence checked in the same cycle as the antecedent
`define BEE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define BEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// Token, operator and verdict codes, stack sizing and the precedence table
// used by the evaluator; the checker shares the verdict codes.
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    TK_OPERAND  = 3'd0,
    TK_NOT      = 3'd1,
    TK_AND      = 3'd2,
    TK_OR       = 3'd3,
    TK_LBRACKET = 3'd4,
    TK_RBRACKET = 3'd5
  } token_kind_e;

  typedef enum logic [2:0] {
    OP_NOT = 3'd0,
    OP_AND = 3'd1,
    OP_OR  = 3'd2,
    OP_LB  = 3'd3,
    OP_RB  = 3'd4,
    OP_END = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    PREC_LT,
    PREC_EQ,
    PREC_GT,
    PREC_ERR
  } prec_e;

  localparam logic [1:0] VERDICT_FALSE = 2'd0;
  localparam logic [1:0] VERDICT_TRUE  = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;

  function automatic op_e tok_to_op(input logic [2:0] kind);
    op_e op;
    case (kind)
      TK_NOT:      op = OP_NOT;
      TK_AND:      op = OP_AND;
      TK_OR:       op = OP_OR;
      TK_LBRACKET: op = OP_LB;
      TK_RBRACKET: op = OP_RB;
      default:     op = OP_END;
    endcase
    return op;
  endfunction

  // rows: operator on top (END when empty), columns: incoming operator
  function automatic prec_e prec_lookup(input op_e top, input op_e nw);
    prec_e p;
    p = PREC_ERR;
    case (top)
      OP_NOT: begin
        case (nw)
          OP_LB:   p = PREC_LT;
          OP_END:  p = PREC_GT;
          default: p = PREC_ERR;
        endcase
      end
      OP_AND: begin
        case (nw)
          OP_NOT, OP_LB: p = PREC_LT;
          OP_AND, OP_OR, OP_RB, OP_END: p = PREC_GT;
          default: p = PREC_ERR;
        endcase
      end
      OP_OR: begin
        case (nw)
          OP_NOT, OP_AND, OP_LB: p = PREC_LT;
          OP_OR, OP_RB, OP_END: p = PREC_GT;
          default: p = PREC_ERR;
        endcase
      end
      OP_LB: begin
        case (nw)
          OP_NOT, OP_AND, OP_OR, OP_LB: p = PREC_LT;
          OP_RB:   p = PREC_EQ;
          default: p = PREC_ERR;
        endcase
      end
      OP_END: begin
        case (nw)
          OP_NOT, OP_AND, OP_OR, OP_LB: p = PREC_LT;
          OP_END:  p = PREC_EQ;
          default: p = PREC_ERR;
        endcase
      end
      default: p = PREC_ERR;
    endcase
    return p;
  endfunction

  function automatic logic is_binary(input op_e op);
    return (op == OP_AND) || (op == OP_OR);
  endfunction

  function automatic logic bool_op(input op_e op, input logic a, input logic b);
    return (op == OP_AND) ? (a & b) : (a | b);
  endfunction

endpackage

// File: hdl/boolean_expression_evaluator.sv
// ----------------------------------------------------------------------------
// boolean_expression_evaluator
// Takes one token per beat (operand with its match bit, NOT, AND, OR or a
// bracket) and evaluates the expression by operator precedence, NOT over AND
// over OR, on an operator stack and a truth-value stack held in two
// synchronous memories of STACK_DEPTH entries. The token flagged last closes
// the expression and yields one verdict beat: false, true or error (malformed
// expression or stack overflow); the block then clears for the next one. A
// token that pushes or merges into a stack top is taken in S_IDLE and run in
// S_EXEC. Every pop refetches the new operator top and every binary step reads
// the second value, each through the memories' registered read port: a closing
// bracket steps through S_RB_POP, S_RB_NOT and, if binary, S_RB_BIN for each
// operator it pops past the first; the last token steps through S_FIN_TOP,
// S_FIN_BIN and S_FIN_NOT per remaining operator, then S_OUT registers the
// verdict, waiting there while the verdict beat before it is still held.
// ----------------------------------------------------------------------------
module boolean_expression_evaluator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] token_kind_i,
  input  logic       operand_match_i,
  input  logic       last_token_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  localparam bee_pkg::cnt_t CNT_ONE   = bee_pkg::cnt_t'(1);
  localparam bee_pkg::cnt_t CNT_TWO   = bee_pkg::cnt_t'(2);
  localparam bee_pkg::cnt_t CNT_ZERO  = bee_pkg::cnt_t'(0);
  localparam bee_pkg::cnt_t CNT_DEPTH = bee_pkg::cnt_t'(bee_pkg::STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_NOT_END,
    S_GT_BIN,
    S_GT_NEXT,
    S_RB_POP,
    S_RB_NOT,
    S_RB_BIN,
    S_FIN_TOP,
    S_FIN_BIN,
    S_FIN_NOT,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  bee_pkg::cnt_t      opcnt_q, opcnt_d;
  bee_pkg::cnt_t      valcnt_q, valcnt_d;
  logic               prev_q, prev_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         verdict_q, verdict_d;
  bee_pkg::op_e       top_op_q, top_op_d;
  logic               top_val_q, top_val_d;
  bee_pkg::op_e       old_q, old_d;
  logic [2:0]         kind_q;
  logic               match_q;
  logic               last_q;

  // stack memories and their registered read data
  bee_pkg::op_e       op_mem [bee_pkg::STACK_DEPTH];
  logic               val_mem [bee_pkg::STACK_DEPTH];
  bee_pkg::op_e       op_rd_q;
  logic               val_rd_q;
  logic               fill_q;

  logic               op_we, op_re, val_we, val_re;
  bee_pkg::addr_t     op_waddr, op_raddr, val_waddr, val_raddr;
  bee_pkg::op_e       op_wdata;
  logic               val_wdata;

  logic               in_accept;
  bee_pkg::op_e       top_live;
  bee_pkg::op_e       top_eff;
  bee_pkg::op_e       nw;
  logic               not_pending;
  bee_pkg::cnt_t      opcnt_m1, opcnt_m2, valcnt_m1, valcnt_m2;
  state_e             done_state;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // after a pop the new top is taken from the read register until top_op_q holds it
  assign top_live    = fill_q ? op_rd_q : top_op_q;
  assign top_eff     = (opcnt_q == CNT_ZERO) ? bee_pkg::OP_END : top_live;
  assign nw          = bee_pkg::tok_to_op(kind_q);
  assign not_pending = (opcnt_q != CNT_ZERO) && (top_live == bee_pkg::OP_NOT);
  assign opcnt_m1    = opcnt_q - CNT_ONE;
  assign opcnt_m2    = opcnt_q - CNT_TWO;
  assign valcnt_m1   = valcnt_q - CNT_ONE;
  assign valcnt_m2   = valcnt_q - CNT_TWO;
  assign done_state  = last_q ? S_FIN_TOP : S_IDLE;

  always_comb begin
    logic bin_r;
    logic flip_v;

    bin_r       = 1'b0;
    flip_v      = 1'b0;
    state_d     = state_q;
    opcnt_d     = opcnt_q;
    valcnt_d    = valcnt_q;
    prev_d      = prev_q;
    err_d       = err_q;
    top_op_d    = top_live;
    top_val_d   = top_val_q;
    old_d       = old_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;

    op_we       = 1'b0;
    op_waddr    = opcnt_q[bee_pkg::ADDR_W-1:0];
    op_wdata    = nw;
    op_re       = 1'b0;
    op_raddr    = opcnt_m2[bee_pkg::ADDR_W-1:0];
    val_we      = 1'b0;
    val_waddr   = valcnt_m1[bee_pkg::ADDR_W-1:0];
    val_wdata   = ~top_val_q;
    val_re      = 1'b0;
    val_raddr   = valcnt_m2[bee_pkg::ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = done_state;
        if (!err_q) begin
          case (kind_q)
            bee_pkg::TK_OPERAND: begin
              if (prev_q) begin
                err_d = 1'b1;
              end else begin
                prev_d = 1'b1;
                if (valcnt_q == CNT_DEPTH) begin
                  err_d = 1'b1;
                end else begin
                  // push the value with a pending NOT already folded in
                  val_we    = 1'b1;
                  val_waddr = valcnt_q[bee_pkg::ADDR_W-1:0];
                  val_wdata = match_q ^ not_pending;
                  top_val_d = match_q ^ not_pending;
                  valcnt_d  = valcnt_q + CNT_ONE;
                  if (not_pending) begin
                    opcnt_d = opcnt_m1;
                    op_re   = 1'b1;
                  end
                end
              end
            end
            bee_pkg::TK_NOT, bee_pkg::TK_AND, bee_pkg::TK_OR,
            bee_pkg::TK_LBRACKET, bee_pkg::TK_RBRACKET: begin
              prev_d = 1'b0;
              case (bee_pkg::prec_lookup(top_eff, nw))
                bee_pkg::PREC_LT: begin
                  if (opcnt_q == CNT_DEPTH) begin
                    err_d = 1'b1;
                  end else begin
                    op_we    = 1'b1;
                    top_op_d = nw;
                    opcnt_d  = opcnt_q + CNT_ONE;
                  end
                end
                bee_pkg::PREC_EQ: begin
                  opcnt_d = opcnt_m1;
                  op_re   = 1'b1;
                  state_d = S_NOT_END;
                end
                bee_pkg::PREC_GT: begin
                  old_d   = top_live;
                  opcnt_d = opcnt_m1;
                  op_re   = 1'b1;
                  val_re  = 1'b1;
                  state_d = S_GT_BIN;
                end
                default: begin
                  err_d = 1'b1;
                end
              endcase
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end

      S_NOT_END: begin
        if (not_pending && (valcnt_q != CNT_ZERO)) begin
          val_we    = 1'b1;
          top_val_d = ~top_val_q;
          opcnt_d   = opcnt_m1;
          op_re     = 1'b1;
        end
        state_d = done_state;
      end

      S_GT_BIN: begin
        if (valcnt_q < CNT_TWO) begin
          err_d   = 1'b1;
          state_d = done_state;
        end else begin
          bin_r     = bee_pkg::bool_op(old_q, top_val_q, val_rd_q);
          flip_v    = bin_r ^ not_pending;
          val_we    = 1'b1;
          val_waddr = valcnt_m2[bee_pkg::ADDR_W-1:0];
          val_wdata = flip_v;
          top_val_d = flip_v;
          valcnt_d  = valcnt_m1;
          if (not_pending) begin
            opcnt_d = opcnt_m1;
            op_re   = 1'b1;
          end
          state_d = S_GT_NEXT;
        end
      end

      S_GT_NEXT: begin
        if (nw == bee_pkg::OP_RB) begin
          state_d = S_RB_POP;
        end else begin
          state_d = done_state;
          if (opcnt_q == CNT_DEPTH) begin
            err_d = 1'b1;
          end else begin
            op_we    = 1'b1;
            top_op_d = nw;
            opcnt_d  = opcnt_q + CNT_ONE;
          end
        end
      end

      S_RB_POP: begin
        if (opcnt_q == CNT_ZERO) begin
          err_d   = 1'b1;
          state_d = done_state;
        end else begin
          old_d   = top_live;
          opcnt_d = opcnt_m1;
          op_re   = 1'b1;
          state_d = S_RB_NOT;
        end
      end

      S_RB_NOT: begin
        if (not_pending && (valcnt_q != CNT_ZERO)) begin
          val_we    = 1'b1;
          top_val_d = ~top_val_q;
          opcnt_d   = opcnt_m1;
          op_re     = 1'b1;
        end
        if (old_q == bee_pkg::OP_LB) begin
          state_d = done_state;
        end else if ((valcnt_q < CNT_TWO) || !bee_pkg::is_binary(old_q)) begin
          err_d   = 1'b1;
          state_d = done_state;
        end else begin
          // second value sits below the top just flipped: no address clash
          val_re  = 1'b1;
          state_d = S_RB_BIN;
        end
      end

      S_RB_BIN: begin
        bin_r     = bee_pkg::bool_op(old_q, top_val_q, val_rd_q);
        val_we    = 1'b1;
        val_waddr = valcnt_m2[bee_pkg::ADDR_W-1:0];
        val_wdata = bin_r;
        top_val_d = bin_r;
        valcnt_d  = valcnt_m1;
        state_d   = S_RB_POP;
      end

      S_FIN_TOP: begin
        if (err_q || (opcnt_q == CNT_ZERO)) begin
          state_d = S_OUT;
        end else if ((bee_pkg::prec_lookup(top_live, bee_pkg::OP_END) != bee_pkg::PREC_GT) ||
                     !bee_pkg::is_binary(top_live) || (valcnt_q < CNT_TWO)) begin
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          old_d   = top_live;
          val_re  = 1'b1;
          state_d = S_FIN_BIN;
        end
      end

      S_FIN_BIN: begin
        bin_r     = bee_pkg::bool_op(old_q, top_val_q, val_rd_q);
        val_we    = 1'b1;
        val_waddr = valcnt_m2[bee_pkg::ADDR_W-1:0];
        val_wdata = bin_r;
        top_val_d = bin_r;
        valcnt_d  = valcnt_m1;
        opcnt_d   = opcnt_m1;
        op_re     = 1'b1;
        state_d   = S_FIN_NOT;
      end

      S_FIN_NOT: begin
        if (not_pending && (valcnt_q != CNT_ZERO)) begin
          val_we    = 1'b1;
          top_val_d = ~top_val_q;
          opcnt_d   = opcnt_m1;
          op_re     = 1'b1;
        end
        state_d = S_FIN_TOP;
      end

      S_OUT: begin
        // hold until the verdict slot is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (err_q || (opcnt_q != CNT_ZERO) || (valcnt_q != CNT_ONE)) begin
            verdict_d = bee_pkg::VERDICT_ERROR;
          end else begin
            verdict_d = top_val_q ? bee_pkg::VERDICT_TRUE : bee_pkg::VERDICT_FALSE;
          end
          opcnt_d  = CNT_ZERO;
          valcnt_d = CNT_ZERO;
          prev_d   = 1'b0;
          err_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opcnt_q     <= CNT_ZERO;
      valcnt_q    <= CNT_ZERO;
      prev_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      opcnt_q     <= opcnt_d;
      valcnt_q    <= valcnt_d;
      prev_q      <= prev_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      fill_q      <= op_re;
    end
  end

  always_ff @(posedge clk_i) begin
    top_op_q  <= top_op_d;
    top_val_q <= top_val_d;
    old_q     <= old_d;
    verdict_q <= verdict_d;
    if (in_accept) begin
      kind_q  <= token_kind_i;
      match_q <= operand_match_i;
      last_q  <= last_token_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      op_mem[op_waddr] <= op_wdata;
    end
    if (op_re) begin
      op_rd_q <= op_mem[op_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (val_re) begin
      val_rd_q <= val_mem[val_raddr];
    end
  end

endmodule

// File: hdl/bee_checker.sv
// ----------------------------------------------------------------------------
// bee_checker
// Port-level checks on the boolean expression evaluator, bound to its top.
// ----------------------------------------------------------------------------
`include "boolean_expression_evaluator_macros.svh"

module bee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // verdict is one of the three defined codes
  `BEE_ASSERT_SAME(a_verdict_code, clk_i, rst_ni, out_valid_o, (verdict_o == bee_pkg::VERDICT_FALSE) || (verdict_o == bee_pkg::VERDICT_TRUE) || (verdict_o == bee_pkg::VERDICT_ERROR), "verdict code out of range")

  // a taken token always keeps the block busy for its execute cycle
  `BEE_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, in_stall_o, "input not stalled after a token beat")

  // no verdict is raised on the cycle after a token is taken
  `BEE_ASSERT_NEXT(a_no_early_verdict, clk_i, rst_ni, in_beat && !out_valid_o, !out_valid_o, "verdict appeared right after a token beat")

  // a held verdict beat keeps its value
  `BEE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(verdict_o), "stalled verdict dropped or changed")

endmodule

bind boolean_expression_evaluator bee_checker u_bee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);
